// ----- src/pla_pkg.sv -----
// ----------------------------------------------------------------------------
// pla_pkg: shared widths, codes and types
// Widths of the point light datapath, register indexes, status codes and
// the sideband structs that travel beside the root and divider cell rows.
// ----------------------------------------------------------------------------
package pla_pkg;

    localparam int COORD_WIDTH_DEF = 16;

    localparam int WORD_W  = 16;           // packed word / coordinate width
    localparam int CFG_W   = 48;           // widest register
    localparam int IDX_W   = 2;            // register index width
    localparam int LANES   = 3;

    localparam int DIFF_W  = WORD_W + 2;   // L - P, signed
    localparam int MAG_W   = WORD_W;       // |L - P| per axis
    localparam int SQ_W    = 2 * MAG_W;
    localparam int S_W     = SQ_W + 2;     // sum of three squares
    localparam int ROOT_W  = 31;           // floor(sqrt(S * 2^28))
    localparam int V_W     = 2 * ROOT_W;   // radicand width
    localparam int REM_W   = ROOT_W + 2;   // root remainder
    localparam int FRAC_SH = V_W - S_W;    // 28 fraction bits of the radicand

    localparam int DIST_W  = 17;
    localparam int DIST_SH = 14;

    localparam int Q_W     = 17;           // quotient bits per divider row
    localparam int DNUM_W  = MAG_W + FRAC_SH + 1;
    localparam int P1_W    = WORD_W + ROOT_W;
    localparam int P2_W    = WORD_W + S_W;
    localparam int DEN_W   = P2_W + 1;
    localparam int CS_W    = 2 * WORD_W;
    localparam int RNUM_W  = DEN_W;

    localparam logic [IDX_W-1:0] REG_POS   = 2'd0;
    localparam logic [IDX_W-1:0] REG_COLOR = 2'd1;
    localparam logic [IDX_W-1:0] REG_SCALE = 2'd2;
    localparam logic [IDX_W-1:0] REG_ATTEN = 2'd3;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_AT_LIGHT   = 2'd1;
    localparam logic [1:0] ST_ATTEN_ZERO = 2'd2;

    localparam logic [WORD_W-1:0] DIR_ONE   = 16'd16384;
    localparam logic [WORD_W-1:0] RAD_MAX   = 16'hFFFF;
    localparam logic [WORD_W-1:0] SCALE_RST = 16'd256;
    localparam logic [CFG_W-1:0]  ATTEN_RST = 48'd256;

    typedef struct packed {
        logic [LANES-1:0][MAG_W-1:0] mag;
        logic [LANES-1:0]            neg;
        logic [S_W-1:0]              s;
    } root_side_t;

    typedef struct packed {
        logic [LANES-1:0]  neg;
        logic              zero;
        logic              den_zero;
        logic [DIST_W-1:0] distance;
    } div_side_t;

endpackage

// ----- src/point_light_attenuation.sv -----
// Throughput: one item per cycle; every stage is a register, so items follow
// back to back and the whole row advances whenever the output slot is free.
// Depth is set by the root row (31 cells) and the divider rows (17 cells).
// Reset (rst_n, async, active low) empties the pipeline and loads the
// register defaults: position 0, color 0, scale 1.0, coefficients a0 = 1.0.
// ----------------------------------------------------------------------------
// point_light_attenuation: point light direction, distance and radiance
// Square root and the six divisions run as rows of identical cells; the
// multiplies and the attenuation sum sit in short stages between the rows.
// ----------------------------------------------------------------------------
module point_light_attenuation #(
    parameter int COORD_WIDTH = pla_pkg::COORD_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [pla_pkg::IDX_W-1:0]          cfg_idx,
    input  logic [pla_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [pla_pkg::WORD_W-1:0]  point_x,
    input  logic signed [pla_pkg::WORD_W-1:0]  point_y,
    input  logic signed [pla_pkg::WORD_W-1:0]  point_z,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [pla_pkg::WORD_W-1:0]  dir_x,
    output logic signed [pla_pkg::WORD_W-1:0]  dir_y,
    output logic signed [pla_pkg::WORD_W-1:0]  dir_z,
    output logic [pla_pkg::DIST_W-1:0]         light_distance,
    output logic [pla_pkg::WORD_W-1:0]         radiance_r,
    output logic [pla_pkg::WORD_W-1:0]         radiance_g,
    output logic [pla_pkg::WORD_W-1:0]         radiance_b,
    output logic [1:0]                         status
);
    import pla_pkg::*;

    // Only the low min(COORD_WIDTH, 16) bits of each coordinate count.
    localparam int CW_EFF = (COORD_WIDTH < WORD_W) ? COORD_WIDTH : WORD_W;

    function automatic logic signed [DIFF_W-1:0] coord_ext(input logic [WORD_W-1:0] w);
        logic [DIFF_W-1:0] e;
        for (int b = 0; b < DIFF_W; b++)
            e[b] = w[(b < CW_EFF) ? b : CW_EFF - 1];
        return $signed(e);
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]  pos_reg;
    logic [CFG_W-1:0]  color_reg;
    logic [WORD_W-1:0] scale_reg;
    logic [CFG_W-1:0]  atten_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            color_reg <= '0;
            scale_reg <= SCALE_RST;
            atten_reg <= ATTEN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_POS:   pos_reg   <= cfg_wdata;
                REG_COLOR: color_reg <= cfg_wdata;
                REG_SCALE: scale_reg <= cfg_wdata[WORD_W-1:0];
                REG_ATTEN: atten_reg <= cfg_wdata;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: every stage moves together; hold all while a result
    // waits in the output register and the consumer is stalled.
    // ------------------------------------------------------------------
    logic adv;
    logic out_valid_reg;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // ------------------------------------------------------------------
    // Stage 1: difference L - P, split into magnitude and sign
    // ------------------------------------------------------------------
    logic [LANES-1:0][WORD_W-1:0] pt_w;
    logic signed [DIFF_W-1:0]     d1 [LANES];
    logic [LANES-1:0][MAG_W-1:0]  mag1_next;
    logic [LANES-1:0]             neg1_next;
    logic                         v1_reg;
    logic [LANES-1:0][MAG_W-1:0]  mag1_reg;
    logic [LANES-1:0]             neg1_reg;

    assign pt_w = {point_z, point_y, point_x};

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            d1[k]        = coord_ext(pos_reg[k*WORD_W +: WORD_W]) - coord_ext(pt_w[k]);
            neg1_next[k] = d1[k][DIFF_W-1];
            mag1_next[k] = neg1_next[k] ? MAG_W'(-d1[k]) : MAG_W'(d1[k]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: squares; stage 3: their sum
    // ------------------------------------------------------------------
    logic                         v2_reg;
    logic [LANES-1:0][SQ_W-1:0]   sq2_reg;
    logic [LANES-1:0][MAG_W-1:0]  mag2_reg;
    logic [LANES-1:0]             neg2_reg;
    logic                         v3_reg;
    logic [S_W-1:0]               s3_reg;
    logic [LANES-1:0][MAG_W-1:0]  mag3_reg;
    logic [LANES-1:0]             neg3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag1_reg <= mag1_next;
            neg1_reg <= neg1_next;
            for (int k = 0; k < LANES; k++)
                sq2_reg[k] <= SQ_W'(mag1_reg[k]) * SQ_W'(mag1_reg[k]);
            mag2_reg <= mag1_reg;
            neg2_reg <= neg1_reg;
            s3_reg   <= S_W'(sq2_reg[0]) + S_W'(sq2_reg[1]) + S_W'(sq2_reg[2]);
            mag3_reg <= mag2_reg;
            neg3_reg <= neg2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Root row: one root bit per cell, radicand S * 2^28
    // ------------------------------------------------------------------
    logic [REM_W-1:0]  rc_rem  [ROOT_W];
    logic [ROOT_W-1:0] rc_root [ROOT_W];
    logic [V_W-1:0]    rc_v    [ROOT_W];
    logic [REM_W-1:0]  rc_rem_in  [ROOT_W];
    logic [ROOT_W-1:0] rc_root_in [ROOT_W];
    logic [V_W-1:0]    rc_v_in    [ROOT_W];
    logic              rvalid_reg [ROOT_W];
    root_side_t        rside_reg  [ROOT_W];

    always_comb
    begin
        for (int i = 0; i < ROOT_W; i++)
        begin
            if (i == 0)
            begin
                rc_rem_in[i]  = '0;
                rc_root_in[i] = '0;
                rc_v_in[i]    = {s3_reg, {FRAC_SH{1'b0}}};
            end
            else
            begin
                rc_rem_in[i]  = rc_rem[i-1];
                rc_root_in[i] = rc_root[i-1];
                rc_v_in[i]    = rc_v[i-1];
            end
        end
    end

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_root
        pla_root_cell u_cell (
            .clk      (clk),
            .en       (adv),
            .rem_in   (rc_rem_in[i]),
            .root_in  (rc_root_in[i]),
            .v_in     (rc_v_in[i]),
            .rem_out  (rc_rem[i]),
            .root_out (rc_root[i]),
            .v_out    (rc_v[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROOT_W; i++)
                rvalid_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            rvalid_reg[0] <= v3_reg;
            for (int i = 1; i < ROOT_W; i++)
                rvalid_reg[i] <= rvalid_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rside_reg[0] <= '{mag: mag3_reg, neg: neg3_reg, s: s3_reg};
            for (int i = 1; i < ROOT_W; i++)
                rside_reg[i] <= rside_reg[i-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: distance, direction dividends, attenuation products
    // ------------------------------------------------------------------
    logic [ROOT_W-1:0]            r_fin;
    root_side_t                   rs_fin;
    logic [ROOT_W:0]              dist_sum;

    logic                         v4_reg;
    logic [ROOT_W-1:0]            r4_reg;
    logic [LANES-1:0]             neg4_reg;
    logic                         zero4_reg;
    logic [DIST_W-1:0]            dist4_reg;
    logic [LANES-1:0][DNUM_W-1:0] dnum4_reg;
    logic [P1_W-1:0]              prod1_4_reg;
    logic [P2_W-1:0]              prod2_4_reg;
    logic [LANES-1:0][CS_W-1:0]   cs4_reg;

    assign r_fin    = rc_root[ROOT_W-1];
    assign rs_fin   = rside_reg[ROOT_W-1];
    // round to nearest: add half of the dropped 14 bits
    assign dist_sum = (ROOT_W+1)'(r_fin) + (ROOT_W+1)'(1 << (DIST_SH - 1));

    // ------------------------------------------------------------------
    // Stage 5: attenuation sum A = a0*2^16 + (a1*R >> 6) + a2*S
    // ------------------------------------------------------------------
    logic                         v5_reg;
    logic [ROOT_W-1:0]            r5_reg;
    logic [LANES-1:0]             neg5_reg;
    logic                         zero5_reg;
    logic [DIST_W-1:0]            dist5_reg;
    logic [LANES-1:0][DNUM_W-1:0] dnum5_reg;
    logic [LANES-1:0][CS_W-1:0]   cs5_reg;
    logic [DEN_W-1:0]             den5_next;
    logic [DEN_W-1:0]             den5_reg;

    assign den5_next = DEN_W'({atten_reg[WORD_W-1:0], {WORD_W{1'b0}}})
                     + DEN_W'(prod1_4_reg[P1_W-1:6])
                     + DEN_W'(prod2_4_reg);

    // ------------------------------------------------------------------
    // Stage 6: load the divider rows, flag quotients that overflow
    // ------------------------------------------------------------------
    logic [LANES-1:0][RNUM_W-1:0] rnum6;
    logic                         v6_reg;
    div_side_t                    side6_reg;
    logic [ROOT_W-1:0]            drem6_reg [LANES];
    logic [Q_W-1:0]               dlow6_reg [LANES];
    logic                         dsat6_reg [LANES];
    logic [ROOT_W-1:0]            ddiv6_reg;
    logic [DEN_W-1:0]             rrem6_reg [LANES];
    logic [Q_W-1:0]               rlow6_reg [LANES];
    logic                         rsat6_reg [LANES];
    logic [DEN_W-1:0]             rdiv6_reg;

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
            rnum6[k] = RNUM_W'({cs5_reg[k], {WORD_W{1'b0}}})
                     + RNUM_W'(den5_reg[DEN_W-1:1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (adv)
        begin
            v4_reg <= rvalid_reg[ROOT_W-1];
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // stage 4
            r4_reg      <= r_fin;
            neg4_reg    <= rs_fin.neg;
            zero4_reg   <= (rs_fin.s == '0);
            dist4_reg   <= dist_sum[DIST_SH +: DIST_W];
            for (int k = 0; k < LANES; k++)
            begin
                dnum4_reg[k] <= DNUM_W'({rs_fin.mag[k], {FRAC_SH{1'b0}}})
                              + DNUM_W'(r_fin[ROOT_W-1:1]);
                cs4_reg[k]   <= CS_W'(color_reg[k*WORD_W +: WORD_W]) * CS_W'(scale_reg);
            end
            prod1_4_reg <= P1_W'(atten_reg[WORD_W +: WORD_W]) * P1_W'(r_fin);
            prod2_4_reg <= P2_W'(atten_reg[2*WORD_W +: WORD_W]) * P2_W'(rs_fin.s);

            // stage 5
            r5_reg    <= r4_reg;
            neg5_reg  <= neg4_reg;
            zero5_reg <= zero4_reg;
            dist5_reg <= dist4_reg;
            dnum5_reg <= dnum4_reg;
            cs5_reg   <= cs4_reg;
            den5_reg  <= den5_next;

            // stage 6
            side6_reg <= '{neg: neg5_reg, zero: zero5_reg,
                           den_zero: (den5_reg == '0), distance: dist5_reg};
            ddiv6_reg <= r5_reg;
            rdiv6_reg <= den5_reg;
            for (int k = 0; k < LANES; k++)
            begin
                drem6_reg[k] <= ROOT_W'(dnum5_reg[k][DNUM_W-1:Q_W]);
                dlow6_reg[k] <= dnum5_reg[k][Q_W-1:0];
                dsat6_reg[k] <= (ROOT_W'(dnum5_reg[k][DNUM_W-1:Q_W]) >= r5_reg);
                rrem6_reg[k] <= DEN_W'(rnum6[k][RNUM_W-1:Q_W]);
                rlow6_reg[k] <= rnum6[k][Q_W-1:0];
                rsat6_reg[k] <= (DEN_W'(rnum6[k][RNUM_W-1:Q_W]) >= den5_reg);
            end
        end
    end

    // ------------------------------------------------------------------
    // Divider rows: three direction lanes (divisor R) and three radiance
    // lanes (divisor A), one quotient bit per cell
    // ------------------------------------------------------------------
    logic [ROOT_W-1:0] dc_rem [LANES][Q_W];
    logic [ROOT_W-1:0] dc_div [LANES][Q_W];
    logic [Q_W-1:0]    dc_low [LANES][Q_W];
    logic [Q_W-1:0]    dc_quo [LANES][Q_W];
    logic              dc_sat [LANES][Q_W];
    logic [DEN_W-1:0]  qc_rem [LANES][Q_W];
    logic [DEN_W-1:0]  qc_div [LANES][Q_W];
    logic [Q_W-1:0]    qc_low [LANES][Q_W];
    logic [Q_W-1:0]    qc_quo [LANES][Q_W];
    logic              qc_sat [LANES][Q_W];
    logic              dvalid_reg [Q_W];
    div_side_t         dside_reg  [Q_W];

    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        for (genvar i = 0; i < Q_W; i++)
        begin : g_step
            if (i == 0)
            begin : g_head
                pla_div_cell #(.DIV_W(ROOT_W), .Q_W(Q_W)) u_dir (
                    .clk     (clk),
                    .en      (adv),
                    .rem_in  (drem6_reg[k]),
                    .div_in  (ddiv6_reg),
                    .low_in  (dlow6_reg[k]),
                    .quo_in  ('0),
                    .sat_in  (dsat6_reg[k]),
                    .rem_out (dc_rem[k][i]),
                    .div_out (dc_div[k][i]),
                    .low_out (dc_low[k][i]),
                    .quo_out (dc_quo[k][i]),
                    .sat_out (dc_sat[k][i])
                );
                pla_div_cell #(.DIV_W(DEN_W), .Q_W(Q_W)) u_rad (
                    .clk     (clk),
                    .en      (adv),
                    .rem_in  (rrem6_reg[k]),
                    .div_in  (rdiv6_reg),
                    .low_in  (rlow6_reg[k]),
                    .quo_in  ('0),
                    .sat_in  (rsat6_reg[k]),
                    .rem_out (qc_rem[k][i]),
                    .div_out (qc_div[k][i]),
                    .low_out (qc_low[k][i]),
                    .quo_out (qc_quo[k][i]),
                    .sat_out (qc_sat[k][i])
                );
            end
            else
            begin : g_body
                pla_div_cell #(.DIV_W(ROOT_W), .Q_W(Q_W)) u_dir (
                    .clk     (clk),
                    .en      (adv),
                    .rem_in  (dc_rem[k][i-1]),
                    .div_in  (dc_div[k][i-1]),
                    .low_in  (dc_low[k][i-1]),
                    .quo_in  (dc_quo[k][i-1]),
                    .sat_in  (dc_sat[k][i-1]),
                    .rem_out (dc_rem[k][i]),
                    .div_out (dc_div[k][i]),
                    .low_out (dc_low[k][i]),
                    .quo_out (dc_quo[k][i]),
                    .sat_out (dc_sat[k][i])
                );
                pla_div_cell #(.DIV_W(DEN_W), .Q_W(Q_W)) u_rad (
                    .clk     (clk),
                    .en      (adv),
                    .rem_in  (qc_rem[k][i-1]),
                    .div_in  (qc_div[k][i-1]),
                    .low_in  (qc_low[k][i-1]),
                    .quo_in  (qc_quo[k][i-1]),
                    .sat_in  (qc_sat[k][i-1]),
                    .rem_out (qc_rem[k][i]),
                    .div_out (qc_div[k][i]),
                    .low_out (qc_low[k][i]),
                    .quo_out (qc_quo[k][i]),
                    .sat_out (qc_sat[k][i])
                );
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < Q_W; i++)
                dvalid_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            dvalid_reg[0] <= v6_reg;
            for (int i = 1; i < Q_W; i++)
                dvalid_reg[i] <= dvalid_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dside_reg[0] <= side6_reg;
            for (int i = 1; i < Q_W; i++)
                dside_reg[i] <= dside_reg[i-1];
        end
    end

    // ------------------------------------------------------------------
    // Output stage: clamp, apply signs, pick the status code
    // ------------------------------------------------------------------
    div_side_t                    ds_fin;
    logic [LANES-1:0][WORD_W-1:0] dmag;
    logic [LANES-1:0][WORD_W-1:0] dir_next;
    logic [LANES-1:0][WORD_W-1:0] rad_next;
    logic [1:0]                   status_next;
    logic [LANES-1:0][WORD_W-1:0] dir_reg;
    logic [LANES-1:0][WORD_W-1:0] rad_reg;
    logic [DIST_W-1:0]            dist_reg;
    logic [1:0]                   status_reg;

    assign ds_fin = dside_reg[Q_W-1];

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            if (dc_sat[k][Q_W-1] || (dc_quo[k][Q_W-1] > Q_W'(DIR_ONE)))
                dmag[k] = DIR_ONE;
            else
                dmag[k] = dc_quo[k][Q_W-1][WORD_W-1:0];

            if (ds_fin.zero)
                dir_next[k] = '0;
            else if (ds_fin.neg[k])
                dir_next[k] = WORD_W'(-dmag[k]);
            else
                dir_next[k] = dmag[k];

            if (qc_sat[k][Q_W-1] || (qc_quo[k][Q_W-1] > Q_W'(RAD_MAX)))
                rad_next[k] = RAD_MAX;
            else
                rad_next[k] = qc_quo[k][Q_W-1][WORD_W-1:0];
        end

        // a point at the light outranks a zero attenuation sum
        priority if (ds_fin.zero)
            status_next = ST_AT_LIGHT;
        else if (ds_fin.den_zero)
            status_next = ST_ATTEN_ZERO;
        else
            status_next = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= dvalid_reg[Q_W-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dir_reg    <= dir_next;
            rad_reg    <= rad_next;
            dist_reg   <= ds_fin.zero ? '0 : ds_fin.distance;
            status_reg <= status_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign dir_x          = $signed(dir_reg[0]);
    assign dir_y          = $signed(dir_reg[1]);
    assign dir_z          = $signed(dir_reg[2]);
    assign light_distance = dist_reg;
    assign radiance_r     = rad_reg[0];
    assign radiance_g     = rad_reg[1];
    assign radiance_b     = rad_reg[2];
    assign status         = status_reg;

endmodule

// ----- src/pla_root_cell.sv -----
// ----------------------------------------------------------------------------
// pla_root_cell: one digit step of the square root row
// Bring down two radicand bits, try the next root bit, register the step.
// ----------------------------------------------------------------------------
module pla_root_cell (
    input  logic                        clk,
    input  logic                        en,
    input  logic [pla_pkg::REM_W-1:0]   rem_in,
    input  logic [pla_pkg::ROOT_W-1:0]  root_in,
    input  logic [pla_pkg::V_W-1:0]     v_in,
    output logic [pla_pkg::REM_W-1:0]   rem_out,
    output logic [pla_pkg::ROOT_W-1:0]  root_out,
    output logic [pla_pkg::V_W-1:0]     v_out
);
    import pla_pkg::*;

    logic [REM_W+1:0]  work;
    logic [REM_W+1:0]  trial;
    logic              take;
    logic [REM_W-1:0]  rem_next;
    logic [ROOT_W-1:0] root_next;
    logic [V_W-1:0]    v_next;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [V_W-1:0]    v_reg;

    always_comb
    begin
        work      = {rem_in, v_in[V_W-1 -: 2]};
        trial     = (REM_W+2)'({root_in, 2'b01});
        take      = (work >= trial);
        rem_next  = take ? REM_W'(work - trial) : REM_W'(work);
        root_next = {root_in[ROOT_W-2:0], take};
        v_next    = {v_in[V_W-3:0], 2'b00};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            v_reg    <= v_next;
        end
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign v_out    = v_reg;

endmodule

// ----- src/pla_div_cell.sv -----
// ----------------------------------------------------------------------------
// pla_div_cell: one restoring step of a divider row
// Shift in the next dividend bit, subtract the divisor when it fits,
// append the quotient bit and hand everything to the next cell.
// ----------------------------------------------------------------------------
module pla_div_cell #(
    parameter int DIV_W = pla_pkg::DEN_W,
    parameter int Q_W   = pla_pkg::Q_W
) (
    input  logic             clk,
    input  logic             en,
    input  logic [DIV_W-1:0] rem_in,
    input  logic [DIV_W-1:0] div_in,
    input  logic [Q_W-1:0]   low_in,
    input  logic [Q_W-1:0]   quo_in,
    input  logic             sat_in,
    output logic [DIV_W-1:0] rem_out,
    output logic [DIV_W-1:0] div_out,
    output logic [Q_W-1:0]   low_out,
    output logic [Q_W-1:0]   quo_out,
    output logic             sat_out
);
    logic [DIV_W:0]   work;
    logic             take;
    logic [DIV_W-1:0] rem_next;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] div_reg;
    logic [Q_W-1:0]   low_reg;
    logic [Q_W-1:0]   quo_reg;
    logic             sat_reg;

    always_comb
    begin
        work     = {rem_in, low_in[Q_W-1]};
        take     = (work >= {1'b0, div_in});
        rem_next = take ? DIV_W'(work - {1'b0, div_in}) : DIV_W'(work);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            div_reg <= div_in;
            low_reg <= {low_in[Q_W-2:0], 1'b0};
            quo_reg <= {quo_in[Q_W-2:0], take};
            sat_reg <= sat_in;
        end
    end

    assign rem_out = rem_reg;
    assign div_out = div_reg;
    assign low_out = low_reg;
    assign quo_out = quo_reg;
    assign sat_out = sat_reg;

endmodule

// ----- src/pla_checker.sv -----
// ----------------------------------------------------------------------------
// pla_checker: port-level checks for the point light block
// Watches the output channel, input readiness and the relation between the result fields.
// ----------------------------------------------------------------------------
module pla_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [pla_pkg::WORD_W-1:0]  dir_x,
    input logic signed [pla_pkg::WORD_W-1:0]  dir_y,
    input logic signed [pla_pkg::WORD_W-1:0]  dir_z,
    input logic [pla_pkg::DIST_W-1:0]         light_distance,
    input logic [pla_pkg::WORD_W-1:0]         radiance_r,
    input logic [1:0]                         status
);
    import pla_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(dir_x) && $stable(light_distance)
        && $stable(radiance_r) && $stable(status))
        else $error("result changed while stalled");

    // an empty output slot never blocks the input side
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // point at the light: zero direction and zero distance
    a_at_light: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_AT_LIGHT |-> dir_x == '0 && dir_y == '0
        && dir_z == '0 && light_distance == '0)
        else $error("nonzero direction at light position");

    // a zero attenuation sum saturates the red radiance
    a_atten_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_ATTEN_ZERO |-> radiance_r == RAD_MAX)
        else $error("radiance not saturated on zero attenuation");

    // direction components stay within unit length
    a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> dir_x <= 16384 && dir_x >= -16384 && dir_y <= 16384
        && dir_y >= -16384 && dir_z <= 16384 && dir_z >= -16384)
        else $error("direction component out of range");

endmodule

bind point_light_attenuation pla_checker u_pla_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .dir_x          (dir_x),
    .dir_y          (dir_y),
    .dir_z          (dir_z),
    .light_distance (light_distance),
    .radiance_r     (radiance_r),
    .status         (status)
);
